>>> rtl/core/mcls_pkg.sv
`timescale 1ns / 1ps

package mcls_pkg;

    // converter sample width
    localparam int SAMPLE_BITS = 14;

    // result field widths
    localparam int RAW_W = 14;
    localparam int PCT_W = 7;
    localparam int OUT_W = 24;

    // scaled numerator: 14-bit difference times 100
    localparam int NUM_W  = 21;
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd6;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd0;
    localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
    localparam logic [PCT_W-1:0]  PCT_ZERO   = 7'd0;

    // register map
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_DRY    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WET    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DETECT = 2'd2;

    localparam logic [RAW_W-1:0] DRY_RESET    = 14'd14000;
    localparam logic [RAW_W-1:0] WET_RESET    = 14'd4000;
    localparam logic [PCT_W-1:0] DETECT_RESET = 7'd20;

    typedef struct packed {
        logic [RAW_W-1:0] dry;
        logic [RAW_W-1:0] wet;
    } t_cal;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] pct;
    } t_map_res;

endpackage

>>> rtl/core/mcls_cell.sv
`timescale 1ns / 1ps

module mcls_cell import mcls_pkg::*; #(
    parameter int W = 14
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic         i_empty,
    input  logic [W-1:0] i_x,
    input  logic         i_prev_take,
    input  logic [W-1:0] i_prev_val,
    output logic         o_take,
    output logic [W-1:0] o_val
);

    logic [W-1:0] r_val;
    logic [W-1:0] n_val;

    // an empty cell sits above every held value
    assign o_take = i_empty || (i_x < r_val);
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        if (o_take) begin
            n_val = i_prev_take ? i_prev_val : i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= n_val;
        end
    end

endmodule

>>> rtl/core/mcls_map.sv
`timescale 1ns / 1ps

module mcls_map import mcls_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RAW_W-1:0] i_med,
    input  t_cal             i_cal,
    output t_map_res         o_res
);

    typedef enum logic [2:0] {
        MS_IDLE  = 3'b001,
        MS_SCALE = 3'b010,
        MS_DIV   = 3'b100
    } t_mstate;

    t_mstate            r_state;
    logic               r_done;
    logic [RAW_W-1:0]   r_ad;
    logic [RAW_W-1:0]   r_ae;
    logic               r_pos;
    logic               r_full;
    logic [NUM_W-1:0]   r_rem;
    logic [PCT_W-1:0]   r_quo;
    logic [STEP_W-1:0]  r_step;
    logic [NUM_W-1:0]   trial;
    logic               ge;
    logic [NUM_W-1:0]   ad_ext;

    assign ad_ext = NUM_W'(r_ad);
    assign trial  = NUM_W'(r_ae) << r_step;
    assign ge     = r_rem >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                MS_IDLE: begin
                    if (i_start) begin
                        r_state <= MS_SCALE;
                    end
                end
                MS_SCALE: begin
                    r_state <= MS_DIV;
                end
                MS_DIV: begin
                    if (r_step == STEP_LAST) begin
                        r_state <= MS_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= MS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            MS_IDLE: begin
                // magnitudes and sign agreement of median-dry and wet-dry
                r_ad  <= (i_med >= i_cal.dry) ? i_med - i_cal.dry : i_cal.dry - i_med;
                r_ae  <= (i_cal.wet >= i_cal.dry) ? i_cal.wet - i_cal.dry
                                                  : i_cal.dry - i_cal.wet;
                r_pos <= ((i_med > i_cal.dry) && (i_cal.wet > i_cal.dry)) ||
                         ((i_med < i_cal.dry) && (i_cal.wet < i_cal.dry));
            end
            MS_SCALE: begin
                // times 100 as 64 + 32 + 4
                r_rem  <= (ad_ext << 6) + (ad_ext << 5) + (ad_ext << 2);
                r_full <= r_ad >= r_ae;
                r_quo  <= PCT_ZERO;
                r_step <= STEP_FIRST;
            end
            MS_DIV: begin
                if (ge) begin
                    r_rem <= r_rem - trial;
                end
                r_quo  <= {r_quo[PCT_W-2:0], ge};
                r_step <= r_step - 1'b1;
            end
            default: begin
                r_step <= STEP_LAST;
            end
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.pct  = !r_pos ? PCT_ZERO : (r_full ? PCT_FULL : r_quo);

endmodule

>>> rtl/core/median_calibrated_level_sensor.sv
`timescale 1ns / 1ps

// median-of-group level sensor: converter samples arrive as input beats and are
// inserted one per beat into a sorted row of GROUP_SIZE cells, so a sample that
// does not close a group leaves the input ready; the beat that closes a group
// leaves the middle cell holding the median, which is then mapped from dry_raw
// (0 %) to wet_raw (100 %) as (median - dry) * 100 / (wet - dry) truncated toward
// zero and clamped to 0..100 (0 when dry equals wet), and the detect flag is
// raised when the percent reaches detect_percent; the map runs a restoring
// divider one quotient bit per cycle; from the closing beat until the result
// is loaded into the output register the block accepts no sample; the result
// sits in that register, so a new group may be collected while the result
// still waits; configuration is written over the register port and used at
// the next result, collected samples are kept
module median_calibrated_level_sensor import mcls_pkg::*; #(
    parameter int GROUP_SIZE  = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample beats
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample
    // result beats
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [OUT_W-1:0]                     m_tdata,   // median_raw, level_percent
    output logic                                 m_tuser,   // detected
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [PADDR_W-1:0]                   paddr,
    input  logic [PDATA_W-1:0]                   pwdata,
    output logic [PDATA_W-1:0]                   prdata,
    output logic                                 pready
);

    localparam int FILL_W = $clog2(GROUP_SIZE);
    localparam int MID    = GROUP_SIZE / 2;
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(GROUP_SIZE - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SORTED = 4'b0010,
        ST_MAP    = 4'b0100,
        ST_EMIT   = 4'b1000
    } t_state;

    t_state              r_state;
    logic [FILL_W-1:0]   r_fill;
    logic [RAW_W-1:0]    r_dry;
    logic [RAW_W-1:0]    r_wet;
    logic [PCT_W-1:0]    r_detect;
    logic [RAW_W-1:0]    r_med;
    logic                r_m_tvalid;
    logic [OUT_W-1:0]    r_m_tdata;
    logic                r_m_tuser;

    logic                in_beat;
    logic                out_free;
    logic                cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [SAMPLE_BITS-1:0] sample;
    logic [RAW_W-1:0]    med_now;
    t_cal                cal;
    t_map_res            map_res;

    logic                    take [GROUP_SIZE];
    logic [SAMPLE_BITS-1:0]  val  [GROUP_SIZE];

    assign s_tready = (r_state == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign out_free = !r_m_tvalid || m_tready;

    // sorted row of cells, lowest value in cell 0
    for (genvar g = 0; g < GROUP_SIZE; g++) begin : g_cell
        localparam logic [FILL_W-1:0] IDX = FILL_W'(g);
        mcls_cell #(
            .W (SAMPLE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_load      (in_beat),
            .i_empty     (IDX >= r_fill),
            .i_x         (sample),
            .i_prev_take ((g == 0) ? 1'b0 : take[(g == 0) ? 0 : g-1]),
            .i_prev_val  (val[(g == 0) ? 0 : g-1]),
            .o_take      (take[g]),
            .o_val       (val[g])
        );
    end

    assign med_now = RAW_W'(val[MID]);
    assign cal.dry = r_dry;
    assign cal.wet = r_wet;

    mcls_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_SORTED),
        .i_med   (med_now),
        .i_cal   (cal),
        .o_res   (map_res)
    );

    // group sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        if (r_fill == FILL_LAST) begin
                            r_fill  <= '0;
                            r_state <= ST_SORTED;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                ST_SORTED: begin
                    r_state <= ST_MAP;
                end
                ST_MAP: begin
                    if (map_res.done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SORTED) begin
            r_med <= med_now;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if ((r_state == ST_EMIT) && out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && out_free) begin
            r_m_tdata <= OUT_W'({map_res.pct, r_med});
            r_m_tuser <= map_res.pct >= r_detect;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;

    // register port, writes complete in the access cycle
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry    <= DRY_RESET;
            r_wet    <= WET_RESET;
            r_detect <= DETECT_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DRY:    r_dry    <= pwdata[RAW_W-1:0];
                REG_WET:    r_wet    <= pwdata[RAW_W-1:0];
                REG_DETECT: r_detect <= pwdata[PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DRY:    prdata = PDATA_W'(r_dry);
            REG_WET:    prdata = PDATA_W'(r_wet);
            REG_DETECT: prdata = PDATA_W'(r_detect);
            default:    prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/mcls_checker.sv
`timescale 1ns / 1ps

module mcls_checker import mcls_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser,
    input logic             pready
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // percent never exceeds full scale, padding stays clear
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[RAW_W+PCT_W-1:RAW_W] <= PCT_FULL) &&
                     (m_tdata[OUT_W-1:RAW_W+PCT_W] == '0))
        else $error("percent out of range");

    // reset leaves no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // register port never waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind median_calibrated_level_sensor mcls_checker u_mcls_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);
